// ===== design/twsm_pkg.sv =====
// Shared types and constants for the three-wire serial master.
// Holds configuration, item structs, phase codes and command codes.
// No dependencies.
`timescale 1ns / 1ps

package twsm_pkg;

    // Configuration register indexes (byte address 4*index)
    localparam logic [1:0] REG_HALF_PERIOD  = 2'd0;
    localparam logic [1:0] REG_SAMPLE_DELAY = 2'd1;
    localparam logic [1:0] REG_TURNAROUND   = 2'd2;
    localparam logic [1:0] REG_RECOVERY     = 2'd3;

    localparam logic [7:0] HALF_PERIOD_RST  = 8'd2;
    localparam logic [7:0] SAMPLE_DELAY_RST = 8'd1;
    localparam logic [7:0] TURNAROUND_RST   = 8'd10;
    localparam logic [7:0] RECOVERY_RST     = 8'd20;

    // Commands
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_WRITE  = 2'd2;
    localparam logic [1:0] FUNC_MOTION = 2'd3;

    // Write flag in the address byte, and the motion register addresses
    localparam logic [7:0] ADDR_WRITE_FLAG = 8'h80;
    localparam logic [7:0] ADDR_MOTION_XL  = 8'h03;
    localparam logic [1:0] MOTION_LAST     = 2'd2;

    // Phases
    localparam logic [3:0] P_IDLE  = 4'd0;
    localparam logic [3:0] P_ALOW  = 4'd1;
    localparam logic [3:0] P_AHIGH = 4'd2;
    localparam logic [3:0] P_TURN  = 4'd3;
    localparam logic [3:0] P_RLOW  = 4'd4;
    localparam logic [3:0] P_RHIGH = 4'd5;
    localparam logic [3:0] P_RECOV = 4'd6;
    localparam logic [3:0] P_WLOW  = 4'd7;
    localparam logic [3:0] P_WHIGH = 4'd8;

    typedef struct packed {
        logic [7:0] recovery;
        logic [7:0] turnaround;
        logic [7:0] sample_delay;
        logic [7:0] half_period;
    } cfg_t;

    // Last field in the lowest bits
    typedef struct packed {
        logic       sdio_in;
        logic [7:0] wdata;
        logic [6:0] reg_addr;
        logic [1:0] func;
    } in_item_t;

    typedef struct packed {
        logic signed [11:0] delta_y;
        logic signed [11:0] delta_x;
        logic [7:0]         read_data;
        logic               done_res;
        logic               busy_res;
        logic               sdio_oe;
        logic               sdio_out;
        logic               sclk;
    } out_item_t;

    localparam int IN_BITS  = $bits(in_item_t);
    localparam int OUT_BITS = $bits(out_item_t);

endpackage

// ===== design/twsm_cfg.sv =====
// APB-style configuration registers of the three-wire serial master.
// Depends on twsm_pkg.
`timescale 1ns / 1ps

module twsm_cfg
    import twsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;
    logic [7:0] rd_val;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period  <= HALF_PERIOD_RST;
            cfg_reg.sample_delay <= SAMPLE_DELAY_RST;
            cfg_reg.turnaround   <= TURNAROUND_RST;
            cfg_reg.recovery     <= RECOVERY_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_HALF_PERIOD:  cfg_reg.half_period  <= pwdata[7:0];
                REG_SAMPLE_DELAY: cfg_reg.sample_delay <= pwdata[7:0];
                REG_TURNAROUND:   cfg_reg.turnaround   <= pwdata[7:0];
                default:          cfg_reg.recovery     <= pwdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_HALF_PERIOD:  rd_val = cfg_reg.half_period;
            REG_SAMPLE_DELAY: rd_val = cfg_reg.sample_delay;
            REG_TURNAROUND:   rd_val = cfg_reg.turnaround;
            default:          rd_val = cfg_reg.recovery;
        endcase
    end

    assign prdata = {24'd0, rd_val};

endmodule

// ===== design/twsm_core.sv =====
// Sequencer state and one-tick next-state logic of the three-wire serial master.
// Depends on twsm_pkg.
`timescale 1ns / 1ps

module twsm_core
    import twsm_pkg::*;
#(
    parameter int WORD_BITS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      step_en,
    input  in_item_t  item,
    output out_item_t res
);

    localparam int BIW = $clog2(WORD_BITS);
    localparam logic [BIW-1:0] BI_TOP = BIW'(WORD_BITS - 1);

    logic [3:0]           phase_reg, phase_next;
    logic [1:0]           command_reg, command_next;
    logic [BIW-1:0]       bit_index_reg, bit_index_next;
    logic [7:0]           tick_count_reg, tick_count_next;
    logic [WORD_BITS-1:0] shift_reg, shift_next;
    logic [7:0]           addr_reg, addr_next;
    logic [1:0]           motion_index_reg, motion_index_next;
    logic [7:0]           x_low_reg, x_low_next;
    logic [7:0]           y_low_reg, y_low_next;
    logic [7:0]           read_hold_reg, read_hold_next;
    logic [11:0]          x_hold_reg, x_hold_next;
    logic [11:0]          y_hold_reg, y_hold_next;

    logic [7:0]           hp;
    logic [7:0]           sd;
    logic [WORD_BITS-1:0] addr_word;
    logic [8:0]           tick_inc;
    logic [7:0]           limit;
    logic                 end_rec;
    logic                 done;
    logic                 sclk, dout, oe, busy;
    logic [7:0]           rx_byte;

    assign hp = (cfg.half_period == 8'd0) ? 8'd1 : cfg.half_period;
    assign sd = (cfg.sample_delay >= hp) ? hp - 8'd1 : cfg.sample_delay;

    always_comb
    begin
        phase_next        = phase_reg;
        command_next      = command_reg;
        bit_index_next    = bit_index_reg;
        tick_count_next   = tick_count_reg;
        shift_next        = shift_reg;
        addr_next         = addr_reg;
        motion_index_next = motion_index_reg;
        x_low_next        = x_low_reg;
        y_low_next        = y_low_reg;
        read_hold_next    = read_hold_reg;
        x_hold_next       = x_hold_reg;
        y_hold_next       = y_hold_reg;
        end_rec           = 1'b0;
        done              = 1'b0;
        sclk              = 1'b1;
        dout              = 1'b0;
        oe                = 1'b1;
        busy              = 1'b1;
        limit             = hp;
        rx_byte           = 8'd0;

        // Start a command only from idle
        if (phase_reg == P_IDLE && item.func != FUNC_TICK)
        begin
            command_next    = item.func;
            bit_index_next  = BI_TOP;
            tick_count_next = 8'd0;
            phase_next      = P_ALOW;
            case (item.func)
                FUNC_READ:  addr_next = {1'b0, item.reg_addr};
                FUNC_WRITE:
                begin
                    shift_next = WORD_BITS'(item.wdata);
                    addr_next  = {1'b0, item.reg_addr} | ADDR_WRITE_FLAG;
                end
                default:
                begin
                    motion_index_next = 2'd0;
                    addr_next         = ADDR_MOTION_XL;
                end
            endcase
        end

        addr_word = WORD_BITS'(addr_next);

        unique case (phase_next)
            P_IDLE:  busy = 1'b0;
            P_ALOW:
            begin
                sclk = 1'b0;
                dout = addr_word[bit_index_next];
            end
            P_AHIGH: dout = addr_word[bit_index_next];
            P_TURN:  oe = 1'b0;
            P_RLOW:
            begin
                sclk = 1'b0;
                oe   = 1'b0;
            end
            P_RHIGH: oe = 1'b0;
            P_RECOV: ;
            P_WLOW:
            begin
                sclk = 1'b0;
                dout = shift_next[bit_index_next];
            end
            default: dout = shift_next[bit_index_next];
        endcase

        if (phase_next == P_RHIGH && tick_count_next == sd)
            shift_next[bit_index_next] = item.sdio_in;

        if (phase_next == P_TURN)
            limit = cfg.turnaround;
        else if (phase_next == P_RECOV)
            limit = cfg.recovery;

        tick_inc = {1'b0, tick_count_next} + 9'd1;

        if (phase_next != P_IDLE)
        begin
            if (tick_inc < {1'b0, limit})
                tick_count_next = tick_inc[7:0];
            else
            begin
                tick_count_next = 8'd0;
                unique case (phase_next)
                    P_ALOW:  phase_next = P_AHIGH;
                    P_RLOW:  phase_next = P_RHIGH;
                    P_WLOW:  phase_next = P_WHIGH;
                    P_TURN:  phase_next = P_RLOW;
                    P_RECOV: end_rec = 1'b1;
                    P_AHIGH:
                    begin
                        if (bit_index_next != '0)
                        begin
                            bit_index_next = bit_index_next - 1'b1;
                            phase_next     = P_ALOW;
                        end
                        else
                        begin
                            bit_index_next = BI_TOP;
                            if (command_next == FUNC_WRITE)
                                phase_next = P_WLOW;
                            else
                            begin
                                shift_next = '0;
                                phase_next = (cfg.turnaround == 8'd0) ? P_RLOW : P_TURN;
                            end
                        end
                    end
                    P_RHIGH:
                    begin
                        if (bit_index_next != '0)
                        begin
                            bit_index_next = bit_index_next - 1'b1;
                            phase_next     = P_RLOW;
                        end
                        else
                        begin
                            bit_index_next = BI_TOP;
                            rx_byte        = shift_next[7:0];
                            read_hold_next = rx_byte;
                            if (command_next == FUNC_MOTION)
                            begin
                                if (motion_index_next == 2'd0)
                                    x_low_next = rx_byte;
                                else if (motion_index_next == 2'd1)
                                    y_low_next = rx_byte;
                                else
                                begin
                                    x_hold_next = {rx_byte[7:4], x_low_next};
                                    y_hold_next = {rx_byte[3:0], y_low_next};
                                end
                            end
                            if (cfg.recovery == 8'd0)
                                end_rec = 1'b1;
                            else
                                phase_next = P_RECOV;
                        end
                    end
                    default:
                    begin
                        if (bit_index_next != '0)
                        begin
                            bit_index_next = bit_index_next - 1'b1;
                            phase_next     = P_WLOW;
                        end
                        else
                        begin
                            bit_index_next = BI_TOP;
                            phase_next     = P_IDLE;
                            done           = 1'b1;
                        end
                    end
                endcase
            end
        end

        // End of recovery: chain the next motion word or finish
        if (end_rec)
        begin
            if (command_next == FUNC_MOTION && motion_index_next < MOTION_LAST)
            begin
                motion_index_next = motion_index_next + 2'd1;
                addr_next         = ADDR_MOTION_XL + {6'd0, motion_index_next};
                bit_index_next    = BI_TOP;
                tick_count_next   = 8'd0;
                phase_next        = P_ALOW;
            end
            else
            begin
                phase_next      = P_IDLE;
                tick_count_next = 8'd0;
                done            = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= P_IDLE;
            command_reg      <= FUNC_TICK;
            bit_index_reg    <= BI_TOP;
            tick_count_reg   <= 8'd0;
            shift_reg        <= '0;
            addr_reg         <= 8'd0;
            motion_index_reg <= 2'd0;
            x_low_reg        <= 8'd0;
            y_low_reg        <= 8'd0;
            read_hold_reg    <= 8'd0;
            x_hold_reg       <= 12'd0;
            y_hold_reg       <= 12'd0;
        end
        else if (step_en)
        begin
            phase_reg        <= phase_next;
            command_reg      <= command_next;
            bit_index_reg    <= bit_index_next;
            tick_count_reg   <= tick_count_next;
            shift_reg        <= shift_next;
            addr_reg         <= addr_next;
            motion_index_reg <= motion_index_next;
            x_low_reg        <= x_low_next;
            y_low_reg        <= y_low_next;
            read_hold_reg    <= read_hold_next;
            x_hold_reg       <= x_hold_next;
            y_hold_reg       <= y_hold_next;
        end
    end

    always_comb
    begin
        res.sclk      = sclk;
        res.sdio_out  = dout;
        res.sdio_oe   = oe;
        res.busy_res  = busy;
        res.done_res  = done;
        res.read_data = read_hold_next;
        res.delta_x   = x_hold_next;
        res.delta_y   = y_hold_next;
    end

endmodule

// ===== design/three_wire_serial_master_motion.sv =====
// Top level of the three-wire serial master with motion read.
// Depends on twsm_pkg, twsm_cfg and twsm_core.
`timescale 1ns / 1ps

// Three-wire half-duplex serial master stepped by one item per tick. Each
// accepted input item is one timing tick: it may start a read, a write or a
// motion read (registers 0x03..0x05 combined into two signed 12-bit deltas),
// and yields exactly one result item with the line levels of that tick and
// the latest read data. The block takes one item per clock as long as the
// result side keeps taking items: an input register feeds the one-tick
// sequencer logic, whose result lands in an output register. Commands that
// arrive while a transfer is running are ignored. Timing registers are
// written over the APB-style port at byte addresses 0x0 (half_period), 0x4
// (sample_delay), 0x8 (turnaround) and 0xC (recovery); write them only while
// the block is idle.
module three_wire_serial_master_motion
    import twsm_pkg::*;
#(
    parameter int WORD_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[1:0], reg_addr[8:2], wdata[16:9], sdio_in[17], zero pad [23:18]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // sclk[0], sdio_out[1], sdio_oe[2], busy_res[3], done_res[4],
    // read_data[12:5], delta_x[24:13], delta_y[36:25], zero pad [39:37]
    output logic [39:0] m_tdata
);

    cfg_t      cfg;
    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t out_reg;
    logic      out_valid_reg;
    out_item_t step_res;
    logic      step_en;
    logic      s_acc;

    twsm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Advance the sequencer whenever an item waits and the result slot frees up
    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;
    assign s_acc    = s_tvalid && s_tready;

    twsm_core #(
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step_en (step_en),
        .item    (in_reg),
        .res     (step_res)
    );

    // Hold the input item until the sequencer consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_acc)
            in_valid_reg <= 1'b1;
        else if (step_en)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
            in_reg <= in_item_t'(s_tdata[IN_BITS-1:0]);
    end

    // Result register: load on each step, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_en)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            out_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(40 - OUT_BITS)'(0), out_reg};

endmodule

// ===== dv/tb_three_wire_serial_master_motion.sv =====
// Self-checking testbench for the three-wire serial master with motion read.
// Streams timing ticks in, predicts every result item with a cycle-free model
// of the sequencer, and uses twsm_pkg plus the top level three_wire_serial_master_motion.
`timescale 1ns / 1ps

module tb_three_wire_serial_master_motion;
    import twsm_pkg::*;

    // Bound on the whole run.
    localparam int CYCLE_LIMIT = 50000;
    // Extra cycles to let the two-stage pipe settle before any register write
    localparam int SETTLE      = 6;
    // Least number of random ticks per random phase
    localparam int RAND_ITEMS  = 20;
    localparam int MAX_REPORTS = 30;

    // Line levels sit in the low five result bits: done, busy, oe, out, sclk.
    // Typed results for the first item of a row, readable at a glance.
    localparam out_item_t EXP_IDLE        = out_item_t'({32'd0, 5'b00101});
    localparam out_item_t EXP_READ_START  = out_item_t'({32'd0, 5'b01100});
    // Write start: address MSB is the write flag, last read byte was 0xFF
    localparam out_item_t EXP_WRITE_START = out_item_t'({24'd0, 8'hFF, 5'b01110});

    logic        clk;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // func[1:0], reg_addr[8:2], wdata[16:9], sdio_in[17], zero pad [23:18]
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // sclk[0], sdio_out[1], sdio_oe[2], busy_res[3], done_res[4],
    // read_data[12:5], delta_x[24:13], delta_y[36:25], zero pad [39:37]
    logic [39:0] m_tdata;

    three_wire_serial_master_motion dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sequencer model: timing registers and transfer state, as they stand
    // after every item accepted so far.
    // ------------------------------------------------------------------
    cfg_t        timing = {RECOVERY_RST, TURNAROUND_RST, SAMPLE_DELAY_RST, HALF_PERIOD_RST};
    logic [3:0]  seq_phase = P_IDLE;
    logic [1:0]  seq_cmd   = FUNC_TICK;
    logic [2:0]  seq_bit   = 3'd7;
    int          seq_ticks = 0;
    logic [7:0]  seq_shift = '0;
    logic [7:0]  seq_addr  = '0;
    logic [1:0]  seq_word  = '0;   // which motion register is on the wire
    logic [7:0]  x_lsb     = '0;
    logic [7:0]  y_lsb     = '0;
    logic [7:0]  last_byte = '0;
    logic [11:0] x_delta   = '0;
    logic [11:0] y_delta   = '0;

    // Expected result items, oldest first
    out_item_t   tick_results_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int started_cmds   = 0;
    int finished_cmds  = 0;
    int reg_writes     = 0;
    int cycle_count    = 0;

    // Put a word on the wire, MSB first
    function automatic void load_word(input logic [7:0] a);
        seq_addr  = a;
        seq_bit   = 3'd7;
        seq_ticks = 0;
        seq_phase = P_ALOW;
    endfunction

    // End of the gap after a read word: chain the next motion register or
    // finish. Returns the done flag.
    function automatic logic end_of_gap();
        if (seq_cmd == FUNC_MOTION && seq_word < MOTION_LAST)
        begin
            seq_word = seq_word + 2'd1;
            load_word(ADDR_MOTION_XL + 8'(seq_word));
            return 1'b0;
        end
        seq_phase = P_IDLE;
        seq_ticks = 0;
        return 1'b1;
    endfunction

    // Advance the sequencer by one tick and produce the result item for it
    task automatic predict_tick(input in_item_t it, output out_item_t r);
        int         hp;
        int         sd;
        int         lim;
        int         t;
        logic [2:0] bi;
        logic [7:0] got;
        logic       done;
        // A zero half period counts as one tick; a late sample falls on the
        // last tick of the high half.
        hp   = (timing.half_period == 8'd0) ? 1 : int'(timing.half_period);
        sd   = (int'(timing.sample_delay) >= hp) ? hp - 1 : int'(timing.sample_delay);
        done = 1'b0;
        r    = '0;
        r.sclk     = 1'b1;
        r.sdio_oe  = 1'b1;
        r.busy_res = 1'b1;

        // Commands start only from idle; anything else is dropped
        if (seq_phase == P_IDLE && it.func != FUNC_TICK)
        begin
            seq_cmd = it.func;
            started_cmds++;
            if (it.func == FUNC_READ)
                load_word({1'b0, it.reg_addr});
            else if (it.func == FUNC_WRITE)
            begin
                seq_shift = it.wdata;
                load_word({1'b0, it.reg_addr} | ADDR_WRITE_FLAG);
            end
            else
            begin
                seq_word = 2'd0;
                load_word(ADDR_MOTION_XL);
            end
        end
        bi = seq_bit;

        // Line levels during this tick
        case (seq_phase)
            P_IDLE:  r.busy_res = 1'b0;
            P_ALOW:
            begin
                r.sclk     = 1'b0;
                r.sdio_out = seq_addr[bi];
            end
            P_AHIGH: r.sdio_out = seq_addr[bi];
            P_TURN:  r.sdio_oe = 1'b0;
            P_RLOW:
            begin
                r.sclk    = 1'b0;
                r.sdio_oe = 1'b0;
            end
            P_RHIGH: r.sdio_oe = 1'b0;
            P_RECOV: ;  // clock high, line driven low
            P_WLOW:
            begin
                r.sclk     = 1'b0;
                r.sdio_out = seq_shift[bi];
            end
            default: r.sdio_out = seq_shift[bi];
        endcase

        if (seq_phase == P_RHIGH && seq_ticks == sd)
            seq_shift[bi] = it.sdio_in;

        if (seq_phase != P_IDLE)
        begin
            t   = seq_ticks + 1;
            lim = hp;
            if (seq_phase == P_TURN)
                lim = timing.turnaround;
            if (seq_phase == P_RECOV)
                lim = timing.recovery;
            if (t < lim)
                seq_ticks = t;
            else
            begin
                seq_ticks = 0;
                case (seq_phase)
                    P_ALOW: seq_phase = P_AHIGH;
                    P_RLOW: seq_phase = P_RHIGH;
                    P_WLOW: seq_phase = P_WHIGH;
                    P_AHIGH:
                        if (bi != 3'd0)
                        begin
                            seq_bit   = bi - 3'd1;
                            seq_phase = P_ALOW;
                        end
                        else if (seq_cmd == FUNC_WRITE)
                        begin
                            seq_bit   = 3'd7;
                            seq_phase = P_WLOW;
                        end
                        else
                        begin
                            // Release the line; skip the turnaround when it is zero
                            seq_bit   = 3'd7;
                            seq_shift = '0;
                            seq_phase = (timing.turnaround == 8'd0) ? P_RLOW : P_TURN;
                        end
                    P_TURN: seq_phase = P_RLOW;
                    P_RHIGH:
                        if (bi != 3'd0)
                        begin
                            seq_bit   = bi - 3'd1;
                            seq_phase = P_RLOW;
                        end
                        else
                        begin
                            seq_bit   = 3'd7;
                            got       = seq_shift;
                            last_byte = got;
                            if (seq_cmd == FUNC_MOTION)
                            begin
                                case (seq_word)
                                    2'd0:    x_lsb = got;
                                    2'd1:    y_lsb = got;
                                    default:
                                    begin
                                        x_delta = {got[7:4], x_lsb};
                                        y_delta = {got[3:0], y_lsb};
                                    end
                                endcase
                            end
                            seq_ticks = 0;
                            if (timing.recovery == 8'd0)
                                done = end_of_gap();
                            else
                                seq_phase = P_RECOV;
                        end
                    P_RECOV: done = end_of_gap();
                    default:
                        if (bi != 3'd0)
                        begin
                            seq_bit   = bi - 3'd1;
                            seq_phase = P_WLOW;
                        end
                        else
                        begin
                            seq_bit   = 3'd7;
                            seq_phase = P_IDLE;
                            done      = 1'b1;
                        end
                endcase
            end
        end

        if (done)
            finished_cmds++;
        r.done_res  = done;
        r.read_data = last_byte;
        r.delta_x   = x_delta;
        r.delta_y   = y_delta;
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one item, with a random gap first when the sender idles. Valid
    // stays high from the previous item when there is no gap. Returns at
    // the edge where the item was taken.
    task automatic send_item(input in_item_t it, input logic typed, input out_item_t typed_res);
        int        gap;
        out_item_t r;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, it};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        predict_tick(it, r);
        tick_results_q.push_back(typed ? typed_res : r);
    endtask

    // A tick with random address and data; the line carries the bit of
    // 'line' that the sequencer is on, so a read returns 'line'.
    function automatic in_item_t make_tick(input logic [1:0] f, input logic [7:0] line);
        in_item_t it;
        it.func     = f;
        it.reg_addr = 7'($urandom);
        it.wdata    = 8'($urandom);
        it.sdio_in  = line[seq_bit];
        return it;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(4))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // Drop valid and hold until every expected item is back and the pipe is empty
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tick_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------

    // Write one timing register, then read it back
    task automatic reg_write(input logic [1:0] idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_HALF_PERIOD:  timing.half_period  = value;
            REG_SAMPLE_DELAY: timing.sample_delay = value;
            REG_TURNAROUND:   timing.turnaround   = value;
            default:          timing.recovery     = value;
        endcase
        reg_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {24'd0, value})
        begin
            mismatches++;
            $display("%0t: register %0d read back, expected %h, actual %h",
                     $time, idx, {24'd0, value}, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_timing(input logic [7:0] hp, input logic [7:0] sd,
                                  input logic [7:0] ta, input logic [7:0] rc);
        wait_drained();
        reg_write(REG_HALF_PERIOD, hp);
        reg_write(REG_SAMPLE_DELAY, sd);
        reg_write(REG_TURNAROUND, ta);
        reg_write(REG_RECOVERY, rc);
    endtask

    // ------------------------------------------------------------------
    // Random traffic: from idle mostly a new command; while busy a random
    // func that must be ignored. The line returns a random byte per read
    // word, with a little noise on top. Runs on until the sequencer is idle.
    // ------------------------------------------------------------------
    task automatic random_traffic(input int n_items);
        in_item_t   it;
        logic [7:0] line;
        logic [1:0] f;
        line = pick_byte();
        for (int n = 0; n < n_items || seq_phase != P_IDLE; n++)
        begin
            if (!(seq_phase inside {P_RLOW, P_RHIGH}))
                line = pick_byte();
            if (seq_phase == P_IDLE)
                f = ($urandom_range(99) < 80) ? 2'($urandom_range(1, 3)) : FUNC_TICK;
            else
                f = 2'($urandom_range(3));
            it = make_tick(f, line);
            if ($urandom_range(99) < 8)
                it.sdio_in = 1'($urandom);
            send_item(it, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed plan: one command per row under the row's timing, then ticks
    // until the transfer ends, with 'poke' as func on every busy tick.
    // ------------------------------------------------------------------
    typedef struct {
        logic [7:0] hp, sd, ta, rc;
        logic [1:0] func;
        logic [6:0] addr;
        logic [7:0] wdata, line;
        logic [1:0] poke;
        logic       typed;
        out_item_t  first;
    } plan_row_t;

    localparam int N_ROWS = 9;

    plan_row_t plan [N_ROWS] = '{
        // func 0 while idle: nothing starts
        '{8'd2, 8'd1, 8'd10, 8'd20, FUNC_TICK, 7'h7F, 8'hFF, 8'hFF, FUNC_TICK, 1'b1, EXP_IDLE},
        // reads at address extremes, line all zeros then all ones; the second
        // one with a zero half period and one-tick gaps
        '{8'd2, 8'd1, 8'd10, 8'd20, FUNC_READ, 7'h7F, 8'h00, 8'h00, FUNC_TICK, 1'b1,
          EXP_READ_START},
        '{8'd0, 8'd0, 8'd1, 8'd1, FUNC_READ, 7'h00, 8'hFF, 8'hFF, FUNC_TICK, 1'b1,
          EXP_READ_START},
        // write at the data extreme
        '{8'd0, 8'd0, 8'd1, 8'd1, FUNC_WRITE, 7'h7F, 8'hFF, 8'h00, FUNC_TICK, 1'b1,
          EXP_WRITE_START},
        // command while busy: reads thrown at a running write
        '{8'd0, 8'd0, 8'd1, 8'd1, FUNC_WRITE, 7'h55, 8'hAA, 8'h5A, FUNC_READ, 1'b0, '0},
        // motion read with the most negative high nibble
        '{8'd0, 8'd0, 8'd1, 8'd1, FUNC_MOTION, 7'h00, 8'h00, 8'h80, FUNC_WRITE, 1'b0, '0},
        // sample delay beyond the half period
        '{8'd2, 8'd7, 8'd1, 8'd1, FUNC_READ, 7'h15, 8'h00, 8'h3C, FUNC_TICK, 1'b0, '0},
        // zero turnaround and zero recovery: motion read of all ones, then a write
        '{8'd1, 8'd0, 8'd0, 8'd0, FUNC_MOTION, 7'h7F, 8'hFF, 8'hFF, FUNC_READ, 1'b0, '0},
        '{8'd1, 8'd0, 8'd0, 8'd0, FUNC_WRITE, 7'h33, 8'hC3, 8'h00, FUNC_MOTION, 1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Output side: take results at random, compare each against the oldest
    // expectation field by field.
    // ------------------------------------------------------------------
    out_item_t want_r;
    out_item_t got_r;

    task automatic compare_field(input string name, input logic [11:0] want,
                                 input logic [11:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tick_results_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, m_tdata);
            end
            else
            begin
                want_r = tick_results_q.pop_front();
                got_r  = out_item_t'(m_tdata[OUT_BITS-1:0]);
                results_seen++;
                compare_field("sclk", 12'(want_r.sclk), 12'(got_r.sclk));
                compare_field("sdio_out", 12'(want_r.sdio_out), 12'(got_r.sdio_out));
                compare_field("sdio_oe", 12'(want_r.sdio_oe), 12'(got_r.sdio_oe));
                compare_field("busy_res", 12'(want_r.busy_res), 12'(got_r.busy_res));
                compare_field("done_res", 12'(want_r.done_res), 12'(got_r.done_res));
                compare_field("read_data", 12'(want_r.read_data), 12'(got_r.read_data));
                compare_field("delta_x", want_r.delta_x, got_r.delta_x);
                compare_field("delta_y", want_r.delta_y, got_r.delta_y);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, tick_results_q.size());
            $display("three_wire_serial_master_motion regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        in_item_t cmd_item;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows, no idling on either side
        foreach (plan[i])
        begin
            if ({plan[i].rc, plan[i].ta, plan[i].sd, plan[i].hp} != timing)
                program_timing(plan[i].hp, plan[i].sd, plan[i].ta, plan[i].rc);
            cmd_item.func     = plan[i].func;
            cmd_item.reg_addr = plan[i].addr;
            cmd_item.wdata    = plan[i].wdata;
            cmd_item.sdio_in  = plan[i].line[seq_bit];
            send_item(cmd_item, plan[i].typed, plan[i].first);
            while (seq_phase != P_IDLE)
                send_item(make_tick(plan[i].poke, plan[i].line), 1'b0, '0);
        end

        // Fastest clock, short gaps, no idling
        program_timing(8'd1, 8'd0, 8'($urandom_range(3)), 8'($urandom_range(3)));
        random_traffic(RAND_ITEMS);

        // Sender mostly idle
        send_idle_pct = 88;
        program_timing(8'd1, 8'd0, 8'($urandom_range(4)), 8'($urandom_range(4)));
        random_traffic(RAND_ITEMS);

        // Receiver mostly stalled; sample delay often past the half period
        send_idle_pct  = 0;
        recv_stall_pct = 88;
        program_timing(8'($urandom_range(1, 2)),
                       ($urandom_range(1) != 0) ? 8'($urandom_range(3)) : 8'd255,
                       8'($urandom_range(4)), 8'($urandom_range(4)));
        random_traffic(RAND_ITEMS);

        // Both sides idling now and then; half period may be zero
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        program_timing(8'($urandom_range(2)), 8'($urandom_range(2)),
                       8'($urandom_range(1)), 8'($urandom_range(6)));
        random_traffic(RAND_ITEMS);

        wait_drained();

        $display("sent %0d tick items and checked %0d results; %0d commands started, %0d done",
                 items_sent, results_seen, started_cmds, finished_cmds);
        $display("%0d register writes over reset, zero, short and late-sample timing, %0d mismatches",
                 reg_writes, mismatches);
        if (mismatches == 0)
            $display("three_wire_serial_master_motion regression: pass");
        else
            $display("three_wire_serial_master_motion regression: fail");
        $finish;
    end

endmodule
